FILE: sv/pwft_pkg.sv
package pwft_pkg;

  localparam int MAX_WORDS      = 512;
  localparam int BITS_PER_WORD  = 10;
  localparam int LEAD_OUT_TICKS = 18;

  localparam int WORD_W  = 16;
  localparam int SLOT_W  = $clog2(MAX_WORDS);
  localparam int LEN_W   = $clog2(MAX_WORDS + 1);
  localparam int COUNT_W = 10;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 4;
  localparam int BIT_IDX_W = $clog2(WORD_W);

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // frame phases
  localparam logic [2:0] PH_PRE_STOP  = 3'd0;
  localparam logic [2:0] PH_PREAMBLE  = 3'd1;
  localparam logic [2:0] PH_DATA_STOP = 3'd2;
  localparam logic [2:0] PH_DATA_WORD = 3'd3;
  localparam logic [2:0] PH_LEAD_OUT  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BIT_TICKS       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BIT_HIGH_TICKS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_BIT_TICKS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_HIGH_TICKS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_PULSE_COUNT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BIT_TICKS       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MARK_TICKS     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MARK_TICKS      = 4'd7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [SLOT_W-1:0]  word_slot;
    logic [WORD_W-1:0]  encoded_word;
    logic [COUNT_W-1:0] frame_words;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_item_t;

endpackage

FILE: sv/pwft_ram.sv
module pwft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/pulse_width_rf_frame_transmitter_unit.sv
// Pulse-width-coded on-off frame transmitter.
//
// Input channel (in_valid/in_stall/in_data) carries one operation per beat:
// load a parity-encoded word into the word store, start a frame with a word
// count, or advance the frame by one tick. Every accepted beat yields exactly
// one result beat on the output channel (out_valid/out_stall/out_data) with
// the line level, the busy flag and a one-beat frame_done flag.
//
// Each result beat is registered the cycle after its input beat; one beat is
// taken every cycle while not stalled: the tick sequencer is a single pass of
// counter compares and increments between the state registers and the result
// register. The word store is a 512 x 16 RAM with registered read, addressed
// by the next word position so the word is ready when the stop bit ends; a
// one-entry bypass covers a load to that slot in the beat just before.
//
// While the result register is full and out_stall is high, in_stall is high
// and the block holds. Synchronous reset (rst) clears all control state and
// loads the register defaults; word store contents are undefined until
// loaded. Configuration writes (cfg_valid/cfg_ready) are always ready and must
// be made only while no frame is running; the block does not enforce this.
module pulse_width_rf_frame_transmitter_unit
  import pwft_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [CFG_W-1:0] stop_bit_ticks, stop_bit_high_ticks;
  logic [CFG_W-1:0] preamble_bit_ticks, preamble_high_ticks, preamble_pulse_count;
  logic [CFG_W-1:0] data_bit_ticks, short_mark_ticks, long_mark_ticks;

  // frame state
  logic [2:0]        phase, phase_next;
  logic [CNT_W-1:0]  tick_count, tick_count_next;
  logic [CNT_W-1:0]  bit_count, bit_count_next;
  logic [SLOT_W-1:0] word_position, word_position_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [WORD_W-1:0] current_word, current_word_next;
  logic              level_reg, level_reg_next;
  logic              sending, sending_next;
  logic              done;

  logic              accept;
  logic              store_we;
  logic [WORD_W-1:0] ram_rd_data, word_rd;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_data;

  logic [CNT_W-1:0]  tick_limit, bit_limit;
  logic [CNT_W:0]    tick_inc, bit_inc;
  logic              tick_wrap, bit_wrap;
  logic [LEN_W-1:0]  pos_inc;
  logic              cur_bit;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign store_we  = accept && (in_data.operation == OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_bit_ticks       <= 8'd1;
      stop_bit_high_ticks  <= 8'd0;
      preamble_bit_ticks   <= 8'd1;
      preamble_high_ticks  <= 8'd0;
      preamble_pulse_count <= 8'd1;
      data_bit_ticks       <= 8'd1;
      short_mark_ticks     <= 8'd0;
      long_mark_ticks      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STOP_BIT_TICKS:       stop_bit_ticks       <= cfg_data;
        CFG_STOP_BIT_HIGH_TICKS:  stop_bit_high_ticks  <= cfg_data;
        CFG_PREAMBLE_BIT_TICKS:   preamble_bit_ticks   <= cfg_data;
        CFG_PREAMBLE_HIGH_TICKS:  preamble_high_ticks  <= cfg_data;
        CFG_PREAMBLE_PULSE_COUNT: preamble_pulse_count <= cfg_data;
        CFG_DATA_BIT_TICKS:       data_bit_ticks       <= cfg_data;
        CFG_SHORT_MARK_TICKS:     short_mark_ticks     <= cfg_data;
        CFG_LONG_MARK_TICKS:      long_mark_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read at the position the sequencer moves to, so the word is waiting
  // when the data stop bit ends.
  pwft_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_WORDS)
  ) u_store (
    .clk     (clk),
    .we      (store_we),
    .wr_addr (in_data.word_slot),
    .wr_data (in_data.encoded_word),
    .rd_addr (word_position_next),
    .rd_data (ram_rd_data)
  );

  // bypass a load that hit the read slot on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= store_we && (in_data.word_slot == word_position_next);
    end
    fwd_data <= in_data.encoded_word;
  end

  assign word_rd = fwd_hit ? fwd_data : ram_rd_data;

  always_comb begin
    unique case (phase)
      PH_PRE_STOP:  tick_limit = stop_bit_ticks;
      PH_PREAMBLE:  tick_limit = preamble_bit_ticks;
      PH_DATA_STOP: tick_limit = stop_bit_ticks;
      PH_DATA_WORD: tick_limit = data_bit_ticks;
      default:      tick_limit = CNT_W'(LEAD_OUT_TICKS);
    endcase
    bit_limit = (phase == PH_PREAMBLE) ? preamble_pulse_count : CNT_W'(BITS_PER_WORD);
  end

  assign tick_inc  = {1'b0, tick_count} + 1'b1;
  assign bit_inc   = {1'b0, bit_count} + 1'b1;
  assign tick_wrap = tick_inc >= {1'b0, tick_limit};
  assign bit_wrap  = bit_inc >= {1'b0, bit_limit};
  assign pos_inc   = LEN_W'(word_position) + 1'b1;
  assign cur_bit   = (bit_count < CNT_W'(WORD_W)) ? current_word[bit_count[BIT_IDX_W-1:0]]
                                                  : 1'b0;

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_count_next     = bit_count;
    word_position_next = word_position;
    frame_length_next  = frame_length;
    current_word_next  = current_word;
    level_reg_next     = level_reg;
    sending_next       = sending;
    done               = 1'b0;

    if (accept && (in_data.operation == OP_START) && !sending) begin
      frame_length_next = (in_data.frame_words > COUNT_W'(MAX_WORDS)) ? LEN_W'(MAX_WORDS)
                                                                      : LEN_W'(in_data.frame_words);
      sending_next      = 1'b1;
    end else if (accept && (in_data.operation == OP_TICK) && sending) begin
      tick_count_next = tick_wrap ? '0 : tick_inc[CNT_W-1:0];
      unique case (phase)
        PH_PRE_STOP: begin
          level_reg_next = tick_count < stop_bit_high_ticks;
          if (tick_wrap) begin
            phase_next = PH_PREAMBLE;
          end
        end
        PH_PREAMBLE: begin
          level_reg_next = tick_count < preamble_high_ticks;
          if (tick_wrap) begin
            bit_count_next = bit_wrap ? '0 : bit_inc[CNT_W-1:0];
            if (bit_wrap) begin
              phase_next = PH_DATA_STOP;
            end
          end
        end
        PH_DATA_STOP: begin
          level_reg_next = tick_count < stop_bit_high_ticks;
          if (tick_wrap) begin
            phase_next        = PH_DATA_WORD;
            current_word_next = word_rd;
          end
        end
        PH_DATA_WORD: begin
          level_reg_next = (tick_count < short_mark_ticks) ||
                           ((tick_count < long_mark_ticks) && !cur_bit);
          if (tick_wrap) begin
            bit_count_next = bit_wrap ? '0 : bit_inc[CNT_W-1:0];
            if (bit_wrap) begin
              if (pos_inc >= frame_length) begin
                word_position_next = '0;
                phase_next         = PH_LEAD_OUT;
              end else begin
                word_position_next = pos_inc[SLOT_W-1:0];
                phase_next         = PH_DATA_STOP;
              end
            end
          end
        end
        default: begin
          level_reg_next = 1'b0;
          if (tick_wrap) begin
            // lead-out over: drop back to idle
            phase_next         = PH_PRE_STOP;
            sending_next       = 1'b0;
            tick_count_next    = '0;
            bit_count_next     = '0;
            word_position_next = '0;
            done               = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PRE_STOP;
      tick_count    <= '0;
      bit_count     <= '0;
      word_position <= '0;
      frame_length  <= '0;
      current_word  <= '0;
      level_reg     <= 1'b0;
      sending       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_count     <= bit_count_next;
      word_position <= word_position_next;
      frame_length  <= frame_length_next;
      current_word  <= current_word_next;
      level_reg     <= level_reg_next;
      sending       <= sending_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.line_level <= level_reg_next;
      out_data.busy_res   <= sending_next;
      out_data.frame_done <= done;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> !out_data.busy_res)
    else $error("frame_done beat still reports busy");

  a_idle_cleared: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (phase == PH_PRE_STOP) && (tick_count == '0) && (bit_count == '0) &&
                 (word_position == '0))
    else $error("sequencer not cleared while idle");

  a_level_only_busy: assert property (@(posedge clk) disable iff (rst)
    level_reg |-> sending)
    else $error("line high with no frame running");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> !sending && !level_reg)
    else $error("frame still running after done");

endmodule
